// File: rtl/core/pcm_format_downmix_to_mono_core_defines.svh
// ----------------------------------------------------------------------------
// PCM downmix assertion macros
// Concurrent assertion helpers on clk_i / rst_ni, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PCM_FORMAT_DOWNMIX_TO_MONO_CORE_DEFINES_SVH
`define PCM_FORMAT_DOWNMIX_TO_MONO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PCMDMX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PCMDMX_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PCMDMX_ASSERT(lbl, prop, msg)
`define PCMDMX_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/core/pcmdmx_pkg.sv
// ----------------------------------------------------------------------------
// PCM downmix package
// Field widths, register indexes, sample formats and Q1.23 limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcmdmx_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int Q_W             = 25;
  localparam int SAMPLE_TYPE_W   = 3;
  localparam int CHANNEL_TOTAL_W = 4;
  localparam int VALID_BITS_W    = 6;
  localparam int CFG_DATA_W      = 6;
  localparam int CFG_IDX_W       = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic signed [Q_W-1:0] Q_POS = 25'sh080_0000;
  localparam logic signed [Q_W-1:0] Q_NEG = -25'sh080_0000;

  typedef enum logic [SAMPLE_TYPE_W-1:0] {
    SMP_PCM8    = 3'd0,
    SMP_PCM16   = 3'd1,
    SMP_PCM24   = 3'd2,
    SMP_PCM32   = 3'd3,
    SMP_FLOAT32 = 3'd4
  } sample_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_TYPE   = 2'd0,
    REG_CHANNEL_TOTAL = 2'd1,
    REG_VALID_BITS    = 2'd2
  } cfg_reg_e;

  localparam logic [SAMPLE_TYPE_W-1:0]   SAMPLE_TYPE_RST   = SMP_PCM16;
  localparam logic [CHANNEL_TOTAL_W-1:0] CHANNEL_TOTAL_RST = 4'd2;
  localparam logic [VALID_BITS_W-1:0]    VALID_BITS_RST    = 6'd32;

endpackage

// File: rtl/core/pcm_format_downmix_to_mono_core.sv
// ----------------------------------------------------------------------------
// PCM downmix to mono core
// Converts interleaved channel samples to Q1.23 and emits one averaged,
// clamped mono sample per frame.
// ----------------------------------------------------------------------------
// The front end takes one channel item per clock, converts it and adds it to
// the frame sum, stalling only when the two-entry frame queue is full. Each
// finished frame is divided by its channel count in a bit-serial divider in
// the back end, one quotient bit per cycle; the result waits in an output
// register while the front keeps accepting items.
`timescale 1ns / 1ps

module pcm_format_downmix_to_mono_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcmdmx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcmdmx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pcmdmx_pkg::SAMPLE_W-1:0]   sample_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pcmdmx_pkg::Q_W-1:0] mono_sample_o
);
  import pcmdmx_pkg::*;

  localparam int PW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = 26 + $clog2(MAX_CHANNELS);
  localparam int DATA_W = SUM_W + CNT_W;

  logic [SAMPLE_TYPE_W-1:0]   sample_type_q;
  logic [CHANNEL_TOTAL_W-1:0] channel_total_q;
  logic [VALID_BITS_W-1:0]    valid_bits_q;

  logic              push_valid;
  logic              push_ready;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_type_q   <= SAMPLE_TYPE_RST;
      channel_total_q <= CHANNEL_TOTAL_RST;
      valid_bits_q    <= VALID_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_TYPE:   sample_type_q   <= cfg_wdata_i[SAMPLE_TYPE_W-1:0];
        REG_CHANNEL_TOTAL: channel_total_q <= cfg_wdata_i[CHANNEL_TOTAL_W-1:0];
        REG_VALID_BITS:    valid_bits_q    <= cfg_wdata_i[VALID_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  pcmdmx_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W),
    .PW           (PW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_type_i   (sample_type_q),
    .channel_total_i (channel_total_q),
    .valid_bits_i    (valid_bits_q),
    .sample_bits_i   (sample_bits_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .push_valid_o    (push_valid),
    .push_data_o     (push_data),
    .push_ready_i    (push_ready)
  );

  pcmdmx_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  pcmdmx_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_data_i    (pop_data),
    .pop_ready_o   (pop_ready),
    .out_valid_o   (out_valid_o),
    .mono_sample_o (mono_sample_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// File: rtl/core/pcmdmx_front.sv
// ----------------------------------------------------------------------------
// PCM downmix front end
// Converts each channel item to Q1.23, accumulates the frame sum and pushes
// the finished sum with its channel count into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmdmx_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int SUM_W        = 29,
  parameter int CNT_W        = 4,
  parameter int PW           = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [pcmdmx_pkg::SAMPLE_TYPE_W-1:0]   sample_type_i,
  input  logic [pcmdmx_pkg::CHANNEL_TOTAL_W-1:0] channel_total_i,
  input  logic [pcmdmx_pkg::VALID_BITS_W-1:0]    valid_bits_i,
  input  logic [pcmdmx_pkg::SAMPLE_W-1:0]        sample_bits_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  output logic                                   push_valid_o,
  output logic [SUM_W+CNT_W-1:0]                 push_data_o,
  input  logic                                   push_ready_i
);
  import pcmdmx_pkg::*;

  logic [PW-1:0]           pos_q, pos_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        pos_inc;
  logic                    frame_end;
  logic                    accept;
  logic signed [Q_W-1:0]   conv;
  logic signed [SUM_W-1:0] sum_next;

  // float32 decode
  logic [7:0]              f_exp;
  logic [22:0]             f_man;
  logic [7:0]              f_sh8;
  logic [23:0]             f_mag;
  logic [Q_W-1:0]          f_val;

  // pcm32 container
  logic [VALID_BITS_W-1:0] vb_eff;
  logic [5:0]              p32_sh;
  logic [SAMPLE_W-1:0]     p32_masked;

  always_comb begin
    if (channel_total_i == '0) begin
      count = CNT_W'(1);
    end else if (int'(channel_total_i) > MAX_CHANNELS) begin
      count = CNT_W'(MAX_CHANNELS);
    end else begin
      count = CNT_W'(channel_total_i);
    end
  end

  always_comb begin
    f_exp = sample_bits_i[30:23];
    f_man = sample_bits_i[22:0];
    f_sh8 = 8'd127 - f_exp;
    if (f_exp == 8'hff && f_man != '0) begin
      f_mag = '0;
    end else if (f_exp >= 8'd127) begin
      f_mag = 24'h80_0000;
    end else if (f_exp == '0 || f_sh8 >= 8'd24) begin
      f_mag = '0;
    end else begin
      f_mag = {1'b1, f_man} >> f_sh8[4:0];
    end
    if (f_exp == 8'hff && f_man != '0) begin
      f_val = '0;
    end else if (sample_bits_i[31]) begin
      f_val = -{1'b0, f_mag};
    end else begin
      f_val = {1'b0, f_mag};
    end
  end

  always_comb begin
    if (valid_bits_i == '0 || valid_bits_i > 6'd32) begin
      vb_eff = 6'd32;
    end else begin
      vb_eff = valid_bits_i;
    end
    if (vb_eff >= 6'd24) begin
      p32_sh = 6'd8;
    end else begin
      p32_sh = 6'd32 - vb_eff;
    end
    p32_masked = sample_bits_i & (32'hffff_ffff << p32_sh);
  end

  always_comb begin
    case (sample_type_i)
      SMP_PCM8:    conv = {{2{~sample_bits_i[7]}}, sample_bits_i[6:0], 16'h0000};
      SMP_PCM16:   conv = {sample_bits_i[15], sample_bits_i[15:0], 8'h00};
      SMP_PCM24:   conv = {sample_bits_i[23], sample_bits_i[23:0]};
      SMP_PCM32:   conv = {p32_masked[31], p32_masked[31:8]};
      SMP_FLOAT32: conv = f_val;
      default:     conv = '0;
    endcase
  end

  assign sum_next  = sum_q + {{(SUM_W-Q_W){conv[Q_W-1]}}, conv};
  assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
  assign frame_end = (pos_inc >= count);
  assign accept    = in_valid_i && push_ready_i;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = accept && frame_end;
  assign push_data_o  = {sum_next, count};

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      if (frame_end) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = PW'(pos_inc);
        sum_d = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

endmodule

// File: rtl/core/pcmdmx_fifo.sv
// ----------------------------------------------------------------------------
// PCM downmix frame queue
// Two-entry queue of finished frame sums between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcm_format_downmix_to_mono_core_defines.svh"

module pcmdmx_fifo #(
  parameter int DATA_W = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output logic [DATA_W-1:0] pop_data_o,
  input  logic              pop_ready_i
);
  import pcmdmx_pkg::*;

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `PCMDMX_ASSERT_NEVER(a_fifo_overflow, push_valid_i && !push_ready_o, "frame push into full queue")
  `PCMDMX_ASSERT(a_fifo_cnt_range, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue fill out of range")
  `PCMDMX_ASSERT(a_fifo_pop_dec, (pop && !push_valid_i) |=> (cnt_q == $past(cnt_q) - 1'b1), "queue fill not decremented on pop")

endmodule

// File: rtl/core/pcmdmx_back.sv
// ----------------------------------------------------------------------------
// PCM downmix back end
// Bit-serial divide of the frame sum by the channel count, clamp to
// [-1, 1] and hold the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcm_format_downmix_to_mono_core_defines.svh"

module pcmdmx_back #(
  parameter int SUM_W = 29,
  parameter int CNT_W = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  input  logic [SUM_W+CNT_W-1:0]             pop_data_i,
  output logic                               pop_ready_o,
  output logic                               out_valid_o,
  output logic signed [pcmdmx_pkg::Q_W-1:0]  mono_sample_o,
  input  logic                               out_ready_i
);
  import pcmdmx_pkg::*;

  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic                  neg_q, neg_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [Q_W-1:0] mono_q, mono_d;

  logic signed [SUM_W-1:0] sum_in;
  logic [CNT_W-1:0]        count_in;
  logic [SUM_W-1:0]        mag_in;
  logic [REM_W-1:0]        rem_sh;
  logic                    ge;
  logic [23:0]             res_mag;
  logic signed [Q_W-1:0]   res;

  assign sum_in   = pop_data_i[SUM_W+CNT_W-1:CNT_W];
  assign count_in = pop_data_i[CNT_W-1:0];
  assign mag_in   = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
  assign rem_sh   = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, div_q});

  always_comb begin
    if (quo_q > SUM_W'(Q_POS)) begin
      res_mag = 24'h80_0000;
    end else begin
      res_mag = quo_q[23:0];
    end
    res = neg_q ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  end

  assign pop_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = mono_q;

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    neg_d       = neg_q;
    step_d      = step_q;
    mono_d      = mono_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          quo_d   = mag_in;
          rem_d   = '0;
          div_d   = count_in;
          neg_d   = sum_in[SUM_W-1];
          step_d  = STEP_W'(SUM_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d  = {quo_q[SUM_W-2:0], ge};
        rem_d  = ge ? REM_W'(rem_sh - {1'b0, div_q}) : rem_sh;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          mono_d      = res;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quo_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      mono_q      <= '0;
    end else begin
      state_q     <= state_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      neg_q       <= neg_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      mono_q      <= mono_d;
    end
  end

  `PCMDMX_ASSERT(a_back_out_range, out_valid_q |-> (mono_q <= Q_POS && mono_q >= Q_NEG), "result outside [-1, 1]")
  `PCMDMX_ASSERT(a_back_rem_lt_div, (state_q == ST_DIV) |-> (rem_q < {1'b0, div_q}), "divider remainder not below divisor")
  `PCMDMX_ASSERT(a_back_div_end, (state_q == ST_DIV && step_q == '0) |=> (state_q == ST_DONE), "divider did not finish")
  `PCMDMX_ASSERT(a_back_div_start, (state_q == ST_IDLE && pop_valid_i) |=> (state_q == ST_DIV && step_q == STEP_W'(SUM_W - 1)), "divider not started on pop")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// PCM downmix to mono core testbench
// Drives channel items in every sample format at fixed and random channel
// counts, predicts the averaged Q1.23 mono result per frame and checks each
// one in order, under random idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcmdmx_pkg::*;

  localparam int MAX_CHANNELS  = 8;
  localparam int Q_ONE         = 8388608;
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 128;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 16;
  localparam int ITEMS_PER_PH  = 110;

  localparam logic [SAMPLE_TYPE_W-1:0] SMP_RESERVED = 3'd5;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [SAMPLE_W-1:0]   bits;
    bit                    known;
    int                    want;
  } stim_row_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_W-1:0]      sample_bits_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic signed [Q_W-1:0]    mono_sample_o;

  // predictor state
  logic [SAMPLE_TYPE_W-1:0]   pred_type;
  logic [CHANNEL_TOTAL_W-1:0] pred_channels;
  logic [VALID_BITS_W-1:0]    pred_valid_bits;
  int                         frame_pos;
  int                         frame_acc;

  logic signed [Q_W-1:0] mono_expect_q[$];
  stim_row_t             stim_rows[$];

  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  pcm_format_downmix_to_mono_core #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_bits_i(sample_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mono_sample_o(mono_sample_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic signed [Q_W-1:0] got,
                                 input logic signed [Q_W-1:0] want);
    $display("%0t: %s: mono_sample got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    logic signed [Q_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mono_expect_q.size() == 0) begin
        report_mismatch("unexpected result", mono_sample_o, '0);
      end else begin
        want = mono_expect_q.pop_front();
        if (mono_sample_o !== want)
          report_mismatch("wrong result", mono_sample_o, want);
      end
    end
  end

  function automatic int float_bits_to_q23(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] mant;
    int          mag;
    int          sh;
    expo = bits[30:23];
    mant = bits[22:0];
    if (expo == 8'hFF && mant != 0)
      return 0;
    if (expo >= 8'd127) begin
      mag = Q_ONE;
    end else begin
      sh = 127 - int'(expo);
      if (expo == 0 || sh >= 24)
        mag = 0;
      else
        mag = int'({1'b1, mant}) >> sh;
    end
    return bits[31] ? -mag : mag;
  endfunction

  function automatic int sample_to_q23(input logic [31:0] bits);
    int raw;
    int vb;
    raw = $signed(bits);
    vb  = int'(pred_valid_bits);
    if (vb == 0 || vb > 32)
      vb = 32;
    case (pred_type)
      SMP_PCM8:    return (int'(bits[7:0]) - 128) * 65536;
      SMP_PCM16:   return int'($signed(bits[15:0])) * 256;
      SMP_PCM24:   return int'($signed(bits[23:0]));
      SMP_PCM32: begin
        if (vb >= 24)
          return raw >>> 8;
        return (raw >>> (32 - vb)) <<< (24 - vb);
      end
      SMP_FLOAT32: return float_bits_to_q23(bits);
      default:     return 0;
    endcase
  endfunction

  // accumulate one channel; return 1 with the average when the frame closes
  function automatic bit accumulate_frame(input logic [31:0] bits,
                                          output logic signed [Q_W-1:0] avg);
    int count;
    int mean;
    count = int'(pred_channels);
    if (count == 0)
      count = 1;
    if (count > MAX_CHANNELS)
      count = MAX_CHANNELS;
    frame_acc = frame_acc + sample_to_q23(bits);
    frame_pos = frame_pos + 1;
    avg = '0;
    if (frame_pos < count)
      return 1'b0;
    mean = frame_acc / count;
    if (mean > Q_ONE)
      mean = Q_ONE;
    if (mean < -Q_ONE)
      mean = -Q_ONE;
    avg = mean[Q_W-1:0];
    frame_acc = 0;
    frame_pos = 0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_sample();
    int          pick;
    logic [31:0] pos_x;
    logic [31:0] neg_x;
    logic [7:0]  expo;
    case (pred_type)
      SMP_PCM8:  begin pos_x = 32'h0000_00FF; neg_x = 32'h0000_0000; end
      SMP_PCM16: begin pos_x = 32'h0000_7FFF; neg_x = 32'h0000_8000; end
      SMP_PCM24: begin pos_x = 32'h007F_FFFF; neg_x = 32'h0080_0000; end
      SMP_PCM32: begin pos_x = 32'h7FFF_FFFF; neg_x = 32'h8000_0000; end
      default:   begin pos_x = 32'h3F80_0000; neg_x = 32'hBF80_0000; end
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return pos_x;
      3: return neg_x;
      default: begin
        if (pred_type != SMP_FLOAT32)
          return $urandom;
        if ($urandom_range(0, 7) == 0)
          expo = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        else
          expo = 8'($urandom_range(100, 130));
        return {1'($urandom_range(0, 1)), expo, 23'($urandom)};
      end
    endcase
  endfunction

  task automatic send_item(input logic [31:0] bits, input bit known, input int kval);
    int                    gap;
    logic signed [Q_W-1:0] avg;
    logic signed [Q_W-1:0] exp_val;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct)
      gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    if (accumulate_frame(bits, avg)) begin
      exp_val       = known ? kval[Q_W-1:0] : avg;
      mono_expect_q = {mono_expect_q, exp_val};
    end
  endtask

  // drop valid, wait for every expected result, then let the pipeline drain
  task automatic settle_block(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mono_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SAMPLE_TYPE:   pred_type       = val[SAMPLE_TYPE_W-1:0];
      REG_CHANNEL_TOTAL: pred_channels   = val[CHANNEL_TOTAL_W-1:0];
      REG_VALID_BITS:    pred_valid_bits = val[VALID_BITS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{1'b1, idx, val, '0, 1'b0, 0};
    stim_rows = {stim_rows, row};
  endfunction

  function automatic void add_item(input logic [31:0] bits, input bit known, input int want);
    stim_row_t row;
    row = '{1'b0, REG_SAMPLE_TYPE, '0, bits, known, want};
    stim_rows = {stim_rows, row};
  endfunction

  initial begin
    logic [SAMPLE_TYPE_W-1:0] st;
    logic [CFG_DATA_W-1:0]    ct;
    logic [CFG_DATA_W-1:0]    vb;

    pred_type       = SAMPLE_TYPE_RST;
    pred_channels   = CHANNEL_TOTAL_RST;
    pred_valid_bits = VALID_BITS_RST;
    frame_pos       = 0;
    frame_acc       = 0;

    // reset configuration: pcm16, two channels
    add_item(32'h0000_7FFF, 1'b0, 0);
    add_item(32'h0000_8000, 1'b1, -128);
    add_cfg(REG_CHANNEL_TOTAL, 6'd0);
    add_item(32'h0000_8000, 1'b1, -Q_ONE);
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_PCM8));
    add_item(32'h0000_0000, 1'b1, -Q_ONE);
    add_item(32'hFFFF_FFFF, 1'b1, 32'h007F_0000);
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_PCM24));
    add_item(32'h007F_FFFF, 1'b1, 32'h007F_FFFF);
    add_item(32'hFF80_0000, 1'b1, -Q_ONE);
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_PCM32));
    add_item(32'h7FFF_FFFF, 1'b1, 32'h007F_FFFF);
    add_item(32'h8000_0000, 1'b1, -Q_ONE);
    add_cfg(REG_VALID_BITS, 6'd1);
    add_item(32'h8000_0000, 1'b1, -Q_ONE);
    add_cfg(REG_VALID_BITS, 6'd16);
    add_item(32'h1234_ABCD, 1'b0, 0);
    add_cfg(REG_VALID_BITS, 6'd0);
    add_item(32'hFFFF_FFFF, 1'b1, -1);
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_FLOAT32));
    add_item(32'h7F80_0000, 1'b1, Q_ONE);
    add_item(32'hFF80_0000, 1'b1, -Q_ONE);
    add_item(32'h7FC0_0000, 1'b1, 0);
    add_item(32'h0000_0001, 1'b1, 0);
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_RESERVED));
    add_item(32'hDEAD_BEEF, 1'b1, 0);
    // full-scale frame at the channel count ceiling
    add_cfg(REG_SAMPLE_TYPE, CFG_DATA_W'(SMP_FLOAT32));
    add_cfg(REG_CHANNEL_TOTAL, 6'd15);
    for (int k = 0; k < MAX_CHANNELS - 1; k++)
      add_item(32'h3F80_0000, 1'b0, 0);
    add_item(32'h3F80_0000, 1'b1, Q_ONE);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        settle_block(SETTLE_CYCLES);
        write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        send_item(stim_rows[i].bits, stim_rows[i].known, stim_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 5)
        st = p[SAMPLE_TYPE_W-1:0];
      else if ($urandom_range(0, 9) < 8)
        st = 3'($urandom_range(0, 4));
      else
        st = 3'($urandom_range(5, 7));
      if (p % 4 == 0)
        ct = 6'd1;
      else if (p % 4 == 1)
        ct = 6'd8;
      else if ($urandom_range(0, 3) == 0)
        ct = 6'($urandom_range(0, 15));
      else
        ct = 6'($urandom_range(1, 8));
      if (p == 3)
        vb = 6'd16;
      else if (p == 8)
        vb = 6'd32;
      else if ($urandom_range(0, 4) == 0)
        vb = 6'($urandom_range(0, 63));
      else
        vb = 6'($urandom_range(16, 32));

      settle_block(SETTLE_CYCLES);
      write_reg(REG_SAMPLE_TYPE, {3'b000, st});
      write_reg(REG_CHANNEL_TOTAL, ct);
      write_reg(REG_VALID_BITS, vb);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase

      for (int n = 0; n < ITEMS_PER_PH; n++)
        send_item(rand_sample(), 1'b0, 0);
    end

    settle_block(TAIL_CYCLES);
    if (err_cnt == 0 && mono_expect_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pcmdmx_pkg.sv
rtl/core/pcmdmx_front.sv
rtl/core/pcmdmx_fifo.sv
rtl/core/pcmdmx_back.sv
rtl/core/pcm_format_downmix_to_mono_core.sv
tb/sv/tb.sv
